// ===== sv/rgt_pkg.sv =====
// Package for the 8x4 binary32 GEMM tile: sizes, command codes and
// binary32 multiply and add functions with round-to-nearest-even.
// Depends on nothing.
`default_nettype none
package rgt_pkg;

  localparam int TileRows = 8;
  localparam int TileCols = 4;
  localparam logic [31:0] CanonNan = 32'h7FC00000;
  localparam logic [31:0] AlphaReset = 32'h3F800000;
  localparam logic [31:0] BetaReset = 32'h00000000;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_B_ROW  = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_ALPHA = 1'b0,
    REG_BETA  = 1'b1
  } reg_index_t;

  // Lane operation selected by the sequencer.
  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_ACC   = 2'd1,
    OP_SCALE = 2'd2
  } lane_op_t;

  typedef struct packed {
    lane_op_t    op;
    logic [1:0]  col;
    logic [31:0] scale_a;
    logic [31:0] scale_c;
  } lane_ctrl_t;

  // Rounds a normalized magnitude: man holds 27 bits with the leading one at
  // bit 26, the low three bits are guard, round and sticky.
  function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] ex,
                                           input logic [26:0] man);
    logic [26:0] m;
    logic [24:0] r;
    logic signed [11:0] e;
    logic sticky;
    int sh;
    m = man;
    e = ex;
    if (e < 12'sd1) begin
      sh = 1 - int'(e);
      if (sh > 27) sh = 27;
      sticky = 1'b0;
      for (int i = 0; i < 27; i++) begin
        if (i < sh && m[i]) sticky = 1'b1;
      end
      m = m >> sh;
      m[0] = m[0] | sticky;
      e = 12'sd0;
    end
    r = {1'b0, m[26:3]};
    if (m[2] && (m[1] || m[0] || m[3])) r = r + 25'd1;
    if (r[24]) begin
      r = r >> 1;
      e = e + 12'sd1;
    end else if (e == 12'sd0 && r[23]) begin
      e = 12'sd1;
    end
    if (e >= 12'sd255) return {sgn, 8'hFF, 23'd0};
    return {sgn, e[7:0], r[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic sa;
    logic sb;
    logic sg;
    logic [7:0] ea;
    logic [7:0] eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] p;
    logic signed [11:0] e;
    logic [26:0] man;
    int lz;
    sa = a[31];
    sb = b[31];
    sg = sa ^ sb;
    ea = a[30:23];
    eb = b[30:23];
    if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) return CanonNan;
    if (ea == 8'hFF || eb == 8'hFF) begin
      if ((ea == 8'hFF && b[30:0] == 0) || (eb == 8'hFF && a[30:0] == 0)) return CanonNan;
      return {sg, 8'hFF, 23'd0};
    end
    if (a[30:0] == 0 || b[30:0] == 0) return {sg, 31'd0};
    ma = {ea != 0, a[22:0]};
    mb = {eb != 0, b[22:0]};
    p = ma * mb;
    e = $signed({4'd0, (ea == 0) ? 8'd1 : ea}) + $signed({4'd0, (eb == 0) ? 8'd1 : eb})
        - 12'sd126;
    lz = 0;
    for (int i = 47; i >= 0; i--) begin
      if (p[i]) begin
        lz = 47 - i;
        break;
      end
    end
    p = p << lz;
    e = e - 12'(lz);
    man = {p[47:22], p[21:0] != 0};
    return fp_round(sg, e, man);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [7:0] ea;
    logic [7:0] eb;
    logic [31:0] x;
    logic [31:0] y;
    logic [49:0] mx;
    logic [49:0] my;
    logic [49:0] s;
    logic signed [11:0] e;
    int d;
    int lz;
    logic sg;
    ea = a[30:23];
    eb = b[30:23];
    if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) return CanonNan;
    if (ea == 8'hFF && eb == 8'hFF) return (a[31] != b[31]) ? CanonNan : a;
    if (ea == 8'hFF) return a;
    if (eb == 8'hFF) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    mx = {1'b0, x[30:23] != 0, x[22:0], 25'd0};
    my = {1'b0, y[30:23] != 0, y[22:0], 25'd0};
    d = int'((x[30:23] == 0) ? 8'd1 : x[30:23]) - int'((y[30:23] == 0) ? 8'd1 : y[30:23]);
    if (d > 49) d = 49;
    for (int i = 0; i < 50; i++) begin
      if (i < d && my[i]) my[0] = 1'b1;
    end
    my = (my >> d) | {49'd0, my[0]};
    if (x[31] == y[31]) s = mx + my;
    else s = mx - my;
    if (s == 0) return 32'd0;
    sg = x[31];
    e = $signed({4'd0, (x[30:23] == 0) ? 8'd1 : x[30:23]}) + 12'sd1;
    lz = 0;
    for (int i = 49; i >= 0; i--) begin
      if (s[i]) begin
        lz = 49 - i;
        break;
      end
    end
    s = s << lz;
    e = e - 12'(lz);
    return fp_round(sg, e, {s[49:24], s[23:0] != 0});
  endfunction

endpackage
`default_nettype wire

// ===== sv/rgt_if.sv =====
// Valid/ready channel interfaces for the GEMM tile.
// Depends on nothing.
`default_nettype none
interface rgt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  column_index;
  logic [31:0] word0, word1, word2, word3, word4, word5, word6, word7;
  modport source (output valid, cmd, column_index, word0, word1, word2, word3, word4,
                  word5, word6, word7, input ready);
  modport sink (input valid, cmd, column_index, word0, word1, word2, word3, word4,
                word5, word6, word7, output ready);
endinterface

interface rgt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_column;
  logic [31:0] res0, res1, res2, res3, res4, res5, res6, res7;
  logic        tile_done;
  modport source (output valid, out_column, res0, res1, res2, res3, res4, res5, res6, res7,
                  tile_done, input ready);
  modport sink (input valid, out_column, res0, res1, res2, res3, res4, res5, res6, res7,
                tile_done, output ready);
endinterface

interface rgt_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/rgt_lane.sv =====
// One row lane: holds the A element and the four accumulators of its row,
// runs one multiply and add per step (two multiplies when scaling) through two registers.
// Depends on rgt_pkg.
`default_nettype none
module rgt_lane (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load_a,
  input  wire logic [31:0]       a_in,
  input  wire rgt_pkg::lane_ctrl_t ctrl,
  input  wire logic [31:0]       b_in,
  input  wire logic [31:0]       c_in,
  output logic [31:0]            res
);
  import rgt_pkg::*;

  logic [31:0] a_reg;
  logic [31:0] acc [TileCols];
  logic [31:0] prod0;
  logic [31:0] prod1;
  lane_ctrl_t  ctrl_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_reg <= '0;
      for (int j = 0; j < TileCols; j++) acc[j] <= '0;
      ctrl_q <= '{op: OP_IDLE, col: '0, scale_a: '0, scale_c: '0};
    end else begin
      if (load_a) a_reg <= a_in;
      ctrl_q <= ctrl;
      case (ctrl_q.op)
        OP_ACC: acc[ctrl_q.col] <= fp_add(acc[ctrl_q.col], prod0);
        OP_SCALE: acc[ctrl_q.col] <= '0;
        default: ;
      endcase
    end
    if (ctrl.op == OP_SCALE) begin
      prod0 <= fp_mul(acc[ctrl.col], ctrl.scale_a);
      prod1 <= fp_mul(c_in, ctrl.scale_c);
    end else begin
      prod0 <= fp_mul(a_reg, b_in);
      prod1 <= '0;
    end
    if (ctrl_q.op == OP_SCALE) res <= fp_add(prod1, prod0);
  end
endmodule
`default_nettype wire

// ===== sv/rgt_seq.sv =====
// Sequencer: takes a command, steps the lanes through B columns or one
// finish step, and signals when the output register loads and when out becomes valid.
// Depends on rgt_pkg.
`default_nettype none
module rgt_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic [1:0]        cmd,
  input  wire logic [1:0]        column_index,
  input  wire logic [31:0]       alpha,
  input  wire logic [31:0]       beta,
  input  wire logic              out_fire,
  output logic                   busy,
  output logic                   res_load,
  output logic                   out_valid,
  output logic [1:0]             out_column,
  output rgt_pkg::lane_ctrl_t    ctrl
);
  import rgt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACC  = 4'b0010,
    S_FIN  = 4'b0100,
    S_WAIT = 4'b1000
  } state_t;

  state_t state;
  logic [1:0] step;
  logic [1:0] pend;

  always_comb begin
    ctrl.op = OP_IDLE;
    ctrl.col = step;
    ctrl.scale_a = alpha;
    ctrl.scale_c = beta;
    if (state == S_ACC) ctrl.op = OP_ACC;
    else if (state == S_FIN && pend == 2'd0) ctrl.op = OP_SCALE;
    if (state == S_FIN) ctrl.col = out_column;
  end

  assign busy = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      res_load <= 1'b0;
      step <= '0;
      pend <= '0;
    end else begin
      res_load <= (state == S_FIN) && (pend == 2'd1);
      if (state == S_WAIT && pend == 2'd2) out_valid <= 1'b1;
      else if (out_fire) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          step <= '0;
          pend <= '0;
          if (in_fire && cmd == CMD_B_ROW) state <= S_ACC;
          else if (in_fire && cmd == CMD_FINISH) begin
            state <= S_FIN;
            out_column <= column_index;
          end
        end
        S_ACC: begin
          step <= step + 2'd1;
          if (step == 2'(TileCols - 1)) begin
            state <= S_WAIT;
            pend <= 2'd1;
          end
        end
        S_FIN: begin
          if (pend == 2'd1) begin
            state <= S_WAIT;
            pend <= 2'd2;
          end else begin
            pend <= pend + 2'd1;
          end
        end
        S_WAIT: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/real_gemm_tile_8x4_top.sv =====
// Top level of the 8x4 binary32 GEMM tile: eight row lanes and a sequencer.
// Depends on rgt_pkg, rgt_if, rgt_lane and rgt_seq.
//
// Channels: in carries a command and eight binary32 words, out carries one
// finished C column, cfg writes alpha (index 0) or beta (index 1).
// A column load leaves in ready. In a B row update the eight lanes apply one
// B column per cycle over the four columns, through the lane multiply and add
// registers. A finish passes through the lane product and result registers
// into the output register; the result then waits there until it is taken,
// and in stays not ready until that transfer. Reset clears the A buffer and
// accumulators to +0.0, sets alpha to 1.0 and beta to 0.0, and drops out valid.
// NaN results appear as 0x7FC00000.
`default_nettype none
module real_gemm_tile_8x4_top #(
  parameter int TILE_ROWS = rgt_pkg::TileRows,
  parameter int TILE_COLS = rgt_pkg::TileCols
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rgt_in_if.sink     in,
  rgt_out_if.source  out,
  rgt_cfg_if.sink    cfg
);
  import rgt_pkg::*;

  logic [31:0] alpha;
  logic [31:0] beta;
  logic [31:0] words [TILE_ROWS];
  logic [31:0] res [TILE_ROWS];
  logic [31:0] res_reg [TILE_ROWS];
  logic busy;
  logic res_load;
  logic in_fire;
  lane_ctrl_t ctrl;

  assign words[0] = in.word0;
  assign words[1] = in.word1;
  assign words[2] = in.word2;
  assign words[3] = in.word3;
  assign words[4] = in.word4;
  assign words[5] = in.word5;
  assign words[6] = in.word6;
  assign words[7] = in.word7;

  assign in.ready = !busy;
  assign in_fire = in.valid && in.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= AlphaReset;
      beta <= BetaReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ALPHA: alpha <= cfg.data;
        REG_BETA: beta <= cfg.data;
        default: ;
      endcase
    end
  end

  // The B row arrives with the command; hold it for the four steps.
  logic [31:0] b_row [TILE_COLS];
  logic [31:0] c_col [TILE_ROWS];
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int j = 0; j < TILE_COLS; j++) b_row[j] <= words[j];
      for (int r = 0; r < TILE_ROWS; r++) c_col[r] <= words[r];
    end
  end

  rgt_seq u_seq (
    .clk(clk), .rst(rst), .in_fire(in_fire), .cmd(in.cmd), .column_index(in.column_index),
    .alpha(alpha), .beta(beta), .out_fire(out.valid && out.ready), .busy(busy),
    .res_load(res_load), .out_valid(out.valid), .out_column(out.out_column), .ctrl(ctrl)
  );

  for (genvar r = 0; r < TILE_ROWS; r++) begin : g_lane
    rgt_lane u_lane (
      .clk(clk), .rst(rst), .load_a(in_fire && in.cmd == CMD_LOAD_A), .a_in(words[r]),
      .ctrl(ctrl), .b_in(b_row[ctrl.col]), .c_in(c_col[r]), .res(res[r])
    );
  end

  // Merge stage: the lane results form the output column register.
  always_ff @(posedge clk) begin
    if (res_load) begin
      for (int r = 0; r < TILE_ROWS; r++) res_reg[r] <= res[r];
    end
  end

  assign out.res0 = res_reg[0];
  assign out.res1 = res_reg[1];
  assign out.res2 = res_reg[2];
  assign out.res3 = res_reg[3];
  assign out.res4 = res_reg[4];
  assign out.res5 = res_reg[5];
  assign out.res6 = res_reg[6];
  assign out.res7 = res_reg[7];
  assign out.tile_done = (out.out_column == 2'(TILE_COLS - 1));
endmodule
`default_nettype wire

// ===== sv/rgt_checker.sv =====
// Port-level checks for the GEMM tile, bound to the top level.
// Depends on rgt_pkg.
`default_nettype none
module rgt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_cmd,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_column,
  input wire logic       tile_done
);
  import rgt_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_column))
    else $error("output changed during stall");
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tile_done == (out_column == 2'(TileCols - 1)))
    else $error("tile_done wrong");
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_cmd == CMD_LOAD_A |=> in_ready && !out_valid)
    else $error("column load not single cycle");
endmodule

bind real_gemm_tile_8x4_top rgt_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready), .in_cmd(in.cmd),
  .out_valid(out.valid), .out_ready(out.ready), .out_column(out.out_column),
  .tile_done(out.tile_done)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the 8x4 binary32 GEMM tile top level.
// Holds a bit-exact binary32 predictor in a small scoreboard class and drives
// the in, out and cfg channels, with random idling on in and out. Depends on rgt_pkg, rgt_if and the top level.
module tb;
  import rgt_pkg::*;

  typedef struct {
    logic [1:0]  col;
    logic [31:0] res[8];
    logic        done;
  } c_column_t;

  class tile_column_board;
    logic [31:0] alpha;
    logic [31:0] beta;
    logic [31:0] a_col[8];
    logic [31:0] acc[32];
    c_column_t   expected_columns[$];
    int          errors;
    int          columns_seen;

    function new();
      alpha = AlphaReset;
      beta = BetaReset;
      foreach (a_col[i]) a_col[i] = 32'd0;
      foreach (acc[i]) acc[i] = 32'd0;
      errors = 0;
      columns_seen = 0;
    endfunction

    static function logic is_nan(logic [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    // Rounds m * 2^e to binary32 with round-to-nearest-even.
    static function logic [31:0] pack_round(logic s, logic [63:0] m, int e);
      int p;
      int sh;
      int be;
      logic [63:0] r;
      logic [63:0] rem;
      logic [63:0] half;
      if (m == 0) return {s, 31'd0};
      p = 0;
      for (int i = 63; i >= 0; i--) begin
        if (m[i]) begin
          p = i;
          break;
        end
      end
      sh = p - 23;
      if (p + e + 127 < 1) sh = -149 - e;
      if (sh <= 0) r = m << (-sh);
      else if (sh > p + 1) r = 0;
      else if (sh == p + 1) r = (m == (64'd1 << p)) ? 64'd0 : 64'd1;
      else begin
        r = m >> sh;
        rem = m - (r << sh);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && r[0])) r = r + 1;
      end
      if (r == (64'd1 << 24)) begin
        r = r >> 1;
        sh++;
      end
      if (r == 0) return {s, 31'd0};
      if (r < (64'd1 << 23)) return {s, 8'd0, r[22:0]};
      be = e + sh + 150;
      if (be >= 255) return {s, 8'hFF, 23'd0};
      return {s, be[7:0], r[22:0]};
    endfunction

    static function int unb_exp(logic [31:0] x);
      return ((x[30:23] == 0) ? 1 : int'(x[30:23])) - 150;
    endfunction

    static function logic [63:0] sig_of(logic [31:0] x);
      return {40'd0, x[30:23] != 0, x[22:0]};
    endfunction

    static function logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
      logic sg;
      sg = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return CanonNan;
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
        if (a[30:0] == 0 || b[30:0] == 0) return CanonNan;
        return {sg, 8'hFF, 23'd0};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {sg, 31'd0};
      return pack_round(sg, sig_of(a) * sig_of(b), unb_exp(a) + unb_exp(b));
    endfunction

    static function logic [31:0] add32(logic [31:0] a, logic [31:0] b);
      logic [31:0] x;
      logic [31:0] y;
      logic [63:0] mx;
      logic [63:0] my;
      logic [63:0] yv;
      logic [63:0] s;
      int d;
      if (is_nan(a) || is_nan(b)) return CanonNan;
      if (a[30:23] == 8'hFF && b[30:23] == 8'hFF) return (a[31] != b[31]) ? CanonNan : a;
      if (a[30:23] == 8'hFF) return a;
      if (b[30:23] == 8'hFF) return b;
      if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
      if (b[30:0] == 0) return a;
      if (a[30:0] == 0) return b;
      if (a[30:0] >= b[30:0]) begin
        x = a;
        y = b;
      end else begin
        x = b;
        y = a;
      end
      mx = sig_of(x) << 30;
      d = unb_exp(x) - unb_exp(y);
      if (d >= 60) my = 64'd1;
      else begin
        yv = sig_of(y) << 30;
        my = yv >> d;
        if ((my << d) != yv) my[0] = 1'b1;
      end
      s = (x[31] == y[31]) ? mx + my : mx - my;
      if (s == 0) return 32'd0;
      return pack_round(x[31], s, unb_exp(x) - 30);
    endfunction

    function void write_reg(reg_index_t idx, logic [31:0] value);
      if (idx == REG_ALPHA) alpha = value;
      else beta = value;
    endfunction

    function void take_command(cmd_t cmd, logic [1:0] col, logic [31:0] w[8]);
      c_column_t c;
      case (cmd)
        CMD_LOAD_A: begin
          foreach (a_col[r]) a_col[r] = w[r];
        end
        CMD_B_ROW: begin
          for (int j = 0; j < TileCols; j++) begin
            for (int r = 0; r < TileRows; r++) begin
              acc[j*TileRows+r] = add32(acc[j*TileRows+r], mul32(a_col[r], w[j]));
            end
          end
        end
        CMD_FINISH: begin
          c.col = col;
          for (int r = 0; r < TileRows; r++) begin
            c.res[r] = add32(mul32(w[r], beta), mul32(acc[col*TileRows+r], alpha));
            acc[col*TileRows+r] = 32'd0;
          end
          c.done = (col == 2'(TileCols - 1));
          expected_columns.push_back(c);
        end
        default: ;
      endcase
    endfunction

    function void match_column(c_column_t got);
      c_column_t want;
      columns_seen++;
      if (expected_columns.size() == 0) begin
        $display("%0t: unexpected column transfer, actual col %0d", $time, got.col);
        errors++;
        return;
      end
      want = expected_columns.pop_front();
      if (got.col !== want.col) begin
        $display("%0t: out_column expected %0d actual %0d", $time, want.col, got.col);
        errors++;
      end
      for (int r = 0; r < 8; r++) begin
        if (got.res[r] !== want.res[r]) begin
          $display("%0t: res%0d col %0d expected %h actual %h", $time, r, want.col,
                   want.res[r], got.res[r]);
          errors++;
        end
      end
      if (got.done !== want.done) begin
        $display("%0t: tile_done expected %b actual %b", $time, want.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic quiet;
  int   cycles;
  int   items_sent;

  tile_column_board board;

  rgt_in_if  in_ch ();
  rgt_out_if out_ch ();
  rgt_cfg_if cfg_ch ();

  real_gemm_tile_8x4_top i_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch),
    .cfg (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic idle_now();
    return !quiet && ($urandom_range(99) < 27);
  endfunction

  function automatic logic [31:0] rand_float();
    logic s;
    s = 1'($urandom_range(1));
    case ($urandom_range(11))
      0: return {s, 31'd0};
      1: return {s, 8'hFF, 23'd0};
      2: return {s, 8'hFF, 23'($urandom_range(23'h7FFFFF, 1))};
      3: return {s, 8'h00, 23'($urandom)};
      4: return {s, 31'h7F7FFFFF};
      5: return {s, 31'h00000001};
      6: return $urandom;
      default: return {s, 8'($urandom_range(134, 120)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_item(cmd_t cmd, logic [1:0] col, logic [31:0] w[8]);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.column_index <= col;
    in_ch.word0 <= w[0];
    in_ch.word1 <= w[1];
    in_ch.word2 <= w[2];
    in_ch.word3 <= w[3];
    in_ch.word4 <= w[4];
    in_ch.word5 <= w[5];
    in_ch.word6 <= w[6];
    in_ch.word7 <= w[7];
    do @(posedge clk); while (!in_ch.ready);
    board.take_command(cmd, col, w);
    items_sent++;
    if (idle_now()) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (idle_now());
    end
  endtask

  task automatic send_random(cmd_t cmd, logic [1:0] col);
    logic [31:0] w[8];
    foreach (w[i]) w[i] = rand_float();
    send_item(cmd, col, w);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_columns.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(reg_index_t idx, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.write_reg(idx, value);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    c_column_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.col = out_ch.out_column;
      got.res[0] = out_ch.res0;
      got.res[1] = out_ch.res1;
      got.res[2] = out_ch.res2;
      got.res[3] = out_ch.res3;
      got.res[4] = out_ch.res4;
      got.res[5] = out_ch.res5;
      got.res[6] = out_ch.res6;
      got.res[7] = out_ch.res7;
      got.done = out_ch.tile_done;
      board.match_column(got);
    end
    out_ch.ready <= !idle_now();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 300000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] w[8];
    logic [31:0] alpha_set[7];
    logic [31:0] beta_set[7];
    int n;
    int pick;
    board = new();
    cycles = 0;
    items_sent = 0;
    quiet = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NONE;
    in_ch.column_index = 2'd0;
    {in_ch.word0, in_ch.word1, in_ch.word2, in_ch.word3} = '0;
    {in_ch.word4, in_ch.word5, in_ch.word6, in_ch.word7} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ALPHA;
    cfg_ch.data = 32'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset scales, extremes in A and B, ignored words and command.
    w = '{32'h7F7FFFFF, 32'h00000001, 32'h7F800000, 32'hFFC12345,
          32'h80000000, 32'h00000000, 32'hFF7FFFFF, 32'h807FFFFF};
    send_item(CMD_LOAD_A, 2'd3, w);
    w = '{32'h3F800000, 32'h40000000, 32'hBF800000, 32'h00800000,
          32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
    send_item(CMD_B_ROW, 2'd2, w);
    w = '{32'h7F800000, 32'hFF800000, 32'h7FC00001, 32'h00000001,
          32'h3F800000, 32'h80000000, 32'h7F7FFFFF, 32'h00000000};
    send_item(CMD_NONE, 2'd1, w);
    for (int c = 0; c < 4; c++) send_item(CMD_FINISH, 2'(c), w);
    drain();
    write_cfg(REG_ALPHA, 32'h7F7FFFFF);
    write_cfg(REG_BETA, 32'h00000001);
    w = '{32'h00400000, 32'h00000003, 32'h3F800001, 32'h7F000000,
          32'h80000001, 32'h3EFFFFFF, 32'h00FFFFFF, 32'h34000000};
    send_item(CMD_LOAD_A, 2'd0, w);
    send_item(CMD_B_ROW, 2'd0, w);
    send_item(CMD_B_ROW, 2'd3, w);
    for (int c = 3; c >= 0; c--) send_item(CMD_FINISH, 2'(c), w);
    drain();

    alpha_set = '{32'h3F800000, 32'h00000000, 32'hFFFFFFFF, 32'h80000001,
                  32'h3FC00000, 32'h7F800000, 32'h00000000};
    beta_set = '{32'h3F800000, 32'h00000000, 32'h7F7FFFFF, 32'hFFFFFFFF,
                 32'hBF000000, 32'h80000000, 32'h00000000};
    alpha_set[6] = $urandom;
    beta_set[6] = $urandom;
    for (int ph = 0; ph < 7; ph++) begin
      write_cfg(REG_ALPHA, alpha_set[ph]);
      write_cfg(REG_BETA, beta_set[ph]);
      quiet = (ph == 3);
      n = 0;
      while (n < 175) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          send_random(cmd_t'($urandom_range(3)), 2'($urandom_range(3)));
          n++;
        end else begin
          for (int k = $urandom_range(4, 1); k > 0; k--) begin
            send_random(CMD_LOAD_A, 2'($urandom_range(3)));
            send_random(CMD_B_ROW, 2'($urandom_range(3)));
            n += 2;
          end
          for (int c = 0; c < 4; c++) begin
            if ($urandom_range(4) != 0) begin
              send_random(CMD_FINISH, 2'($urandom_range(3)));
              n++;
            end
          end
        end
        if (ph == 2 && n > 80 && n < 90) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (board.expected_columns.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("Sent %0d items over seven alpha/beta settings; checked %0d C columns.",
             items_sent, board.columns_seen);
    if (board.errors == 0 && board.expected_columns.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
